[hw/rtl/pdcs_pkg.sv]
// Package: shared types and constants for the proper divisor count/sum core.
`default_nettype none

package pdcs_pkg;

    localparam int NUMBER_WIDTH_DEF = 24;
    localparam int IN_W             = 24;
    localparam int COUNT_W          = 10;
    localparam int SUM_W            = 27;
    localparam int COUNT_MAX        = 1023;
    localparam int SUM_MAX          = 134217727;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ACC,
        S_FINAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic acc;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sq_le_n;
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/proper_divisor_count_sum_core.sv]
// Top level: proper divisor count, sum and perfect flag by trial division.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+-------------------------
//  input   | i_number                                       | start & !busy
//  result  | o_divisor_count, o_divisor_sum, o_is_perfect   | o_valid, one-cycle strobe
//
// Each candidate i goes through check, a bit-serial restoring divide and accumulate;
// candidates are tried in turn on the single shared divider while i*i <= n.
// The result strobe comes in the first cycle with busy low.
// Reset (synchronous, active low) returns the controller to idle and clears o_valid.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module proper_divisor_count_sum_core
    import pdcs_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [IN_W-1:0]    i_number,
    output logic                    o_valid,
    output logic [COUNT_W-1:0]      o_divisor_count,
    output logic [SUM_W-1:0]        o_divisor_sum,
    output logic                    o_is_perfect
);

    t_cmd    cmd;
    t_status status;

    pdcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pdcs_dpath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_number        (i_number),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_divisor_count (o_divisor_count),
        .o_divisor_sum   (o_divisor_sum),
        .o_is_perfect    (o_is_perfect)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    a_perfect_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_perfect) |-> (o_divisor_count != '0))
        else $error("perfect flag with no divisors");
`endif

endmodule

`default_nettype wire

[hw/rtl/pdcs_ctrl.sv]
// Controller state machine: sequences candidate checks, trial divides and accumulation.
`default_nettype none

module pdcs_ctrl
    import pdcs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                // keep going while i*i <= n
                if (i_status.sq_le_n) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CHECK;
            end
            S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/pdcs_dpath.sv]
// Datapath: candidate/square registers, restoring divider, accumulators, result registers.
`default_nettype none

module pdcs_dpath
    import pdcs_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [IN_W-1:0]    i_number,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic                    o_valid,
    output logic [COUNT_W-1:0]      o_divisor_count,
    output logic [SUM_W-1:0]        o_divisor_sum,
    output logic                    o_is_perfect
);

    localparam int NW  = NUMBER_WIDTH;
    localparam int IW  = (NW + 1) / 2 + 1;        // candidate, up to floor(sqrt(n))+1
    localparam int SQW = 2 * IW;
    localparam int CW  = IW + 2;
    localparam int SW  = NW + 3;                  // sigma(n) < 8n
    localparam int BW  = $clog2(NW);
    localparam int XC  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int XS  = (SW > SUM_W) ? SW : SUM_W;

    logic [NW-1:0]  r_n;
    logic [IW-1:0]  r_i;
    logic [SQW-1:0] r_sq;
    logic [NW-1:0]  r_dvd;
    logic [IW-1:0]  r_rem;
    logic [NW-1:0]  r_quo;
    logic [BW-1:0]  r_bits;
    logic [CW-1:0]  r_cnt;
    logic [SW-1:0]  r_sum;

    logic [IW:0]    trial;
    logic [IW:0]    diff;
    logic           fits;
    logic [CW-1:0]  cnt_prop;
    logic [SW-1:0]  sum_prop;
    logic [XC-1:0]  cnt_ext;
    logic [XS-1:0]  sum_ext;

    assign trial = {r_rem, r_dvd[NW-1]};
    assign diff  = trial - {1'b0, r_i};
    assign fits  = (trial >= {1'b0, r_i});

    assign o_status.sq_le_n  = (r_sq <= SQW'(r_n));
    assign o_status.div_last = (r_bits == '0);

    // drop the number itself, always found as the cofactor of one
    assign cnt_prop = r_cnt - CW'(r_n != '0);
    assign sum_prop = r_sum - SW'(r_n);
    assign cnt_ext  = XC'(cnt_prop);
    assign sum_ext  = XS'(sum_prop);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= NW'(i_number);
            r_i   <= IW'(1);
            r_sq  <= SQW'(1);
            r_cnt <= '0;
            r_sum <= '0;
        end
        if (i_cmd.div_init) begin
            r_dvd  <= r_n;
            r_rem  <= '0;
            r_quo  <= '0;
            r_bits <= BW'(NW - 1);
        end
        if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[NW-2:0], 1'b0};
            r_rem  <= fits ? diff[IW-1:0] : trial[IW-1:0];
            r_quo  <= {r_quo[NW-2:0], fits};
            r_bits <= r_bits - BW'(1);
        end
        if (i_cmd.acc) begin
            if (r_rem == '0) begin
                if (r_quo == NW'(r_i)) begin
                    r_cnt <= r_cnt + CW'(1);
                    r_sum <= r_sum + SW'(r_i);
                end else begin
                    r_cnt <= r_cnt + CW'(2);
                    r_sum <= r_sum + SW'(r_i) + SW'(r_quo);
                end
            end
            // (i+1)^2 = i^2 + 2i + 1
            r_sq <= r_sq + SQW'({r_i, 1'b1});
            r_i  <= r_i + IW'(1);
        end
        if (i_cmd.finish) begin
            o_divisor_count <= (cnt_ext > XC'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                          : COUNT_W'(cnt_ext);
            o_divisor_sum   <= (sum_ext > XS'(SUM_MAX)) ? SUM_W'(SUM_MAX)
                                                        : SUM_W'(sum_ext);
            o_is_perfect    <= (r_n != '0) && (sum_prop == SW'(r_n));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for proper_divisor_count_sum_core: directed and random numbers, scoreboard check.
`timescale 1ns / 1ps

module tb;
    import pdcs_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   total;
        logic               perfect;
    } aliquot_t;

    // Keeps the expected aliquot results in acceptance order and checks each strobe.
    class aliquot_ledger;
        aliquot_t pending[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Trial division over every i with i*i <= n; a square root counts once.
        function aliquot_t aliquot_of(logic [IN_W-1:0] number);
            longint unsigned n;
            longint unsigned i;
            longint unsigned cof;
            longint unsigned cnt;
            longint unsigned total;
            aliquot_t r;
            n = longint'(number) & ((64'd1 << NUMBER_WIDTH_DEF) - 64'd1);
            cnt = 0;
            total = 0;
            for (i = 1; i * i <= n; i++) begin
                if (n % i == 0) begin
                    cof = n / i;
                    if (cof == i) begin
                        cnt += 1;
                        total += i;
                    end else begin
                        cnt += 2;
                        total += i + cof;
                    end
                end
            end
            // n itself shows up as the cofactor of 1
            if (n != 0) begin
                cnt -= 1;
                total -= n;
            end
            r.perfect = (n != 0) && (total == n);
            if (cnt > COUNT_MAX) cnt = COUNT_MAX;
            if (total > SUM_MAX) total = SUM_MAX;
            r.count = cnt[COUNT_W-1:0];
            r.total = total[SUM_W-1:0];
            return r;
        endfunction

        function void note_number(logic [IN_W-1:0] number);
            pending.push_back(aliquot_of(number));
        endfunction

        function void check_result(logic [COUNT_W-1:0] count, logic [SUM_W-1:0] total,
                                   logic perfect);
            aliquot_t want;
            if (pending.size() == 0) begin
                $error("result with nothing pending: count %0d sum %0d perfect %0b",
                       count, total, perfect);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (count !== want.count) begin
                $error("divisor_count: expected %0d, got %0d", want.count, count);
                mismatches++;
            end
            if (total !== want.total) begin
                $error("divisor_sum: expected %0d, got %0d", want.total, total);
                mismatches++;
            end
            if (perfect !== want.perfect) begin
                $error("is_perfect: expected %0b, got %0b", want.perfect, perfect);
                mismatches++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [IN_W-1:0]    i_number;
    logic               o_valid;
    logic [COUNT_W-1:0] o_divisor_count;
    logic [SUM_W-1:0]   o_divisor_sum;
    logic               o_is_perfect;

    aliquot_ledger ledger = new();

    proper_divisor_count_sum_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_number        (i_number),
        .o_valid         (o_valid),
        .o_divisor_count (o_divisor_count),
        .o_divisor_sum   (o_divisor_sum),
        .o_is_perfect    (o_is_perfect)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Worst case for the ~100 items is far below this.
    initial begin
        #400_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            ledger.check_result(o_divisor_count, o_divisor_sum, o_is_perfect);
    end

    // Hands one number to the core; returns at the edge that takes it.
    task automatic feed_number(input logic [IN_W-1:0] num, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_number <= num;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_number(num);
    endtask

    // Mostly short numbers; cost grows with sqrt(n), so full width is rare.
    function automatic logic [IN_W-1:0] pick_number();
        int unsigned r;
        int unsigned w;
        int unsigned k;
        r = $urandom_range(99);
        if (r < 3)
            return IN_W'($urandom_range((1 << IN_W) - 1, 0));
        if (r < 4)
            return '0;
        if (r < 9) begin
            case ($urandom_range(3))
                0: return 6;
                1: return 28;
                2: return 496;
                default: return 8128;
            endcase
        end
        if (r < 15) begin
            k = $urandom_range(255, 1);
            return IN_W'(k * k);
        end
        w = $urandom_range(16, 1);
        return IN_W'($urandom_range((1 << w) - 1, 1 << (w - 1)));
    endfunction

    localparam int N_DIRECTED = 22;
    logic [IN_W-1:0] directed_numbers [N_DIRECTED] = '{
        0, 1, 2, 3, 4, 6, 9, 12, 28, 97, 220, 284, 496, 1024, 8128, 21845,
        65536, 65535, 720720, 8648640, 16769025, 16777215
    };
    int sender_idle [4] = '{0, 57, 0, 34};

    initial begin
        int waited;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_number <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_numbers[j])
            feed_number(directed_numbers[j], 0);
        foreach (sender_idle[p])
            repeat (20) feed_number(pick_number(), sender_idle[p]);
        start <= 1'b0;

        // one item may still be in progress
        waited = 0;
        while (ledger.pending.size() != 0 && waited < 200_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (5) @(posedge i_clk);

        if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (ledger.pending.size() != 0)
                $error("%0d results never arrived", ledger.pending.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
